// ===== sv/rcci_pkg.sv =====
// Shared types and codes for the capped cylinder ray intersection pipeline.
// No dependencies; every other file of the block imports this package.
package rcci_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned SqrtSteps = 64;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned DivLanes  = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_RADIUS_SQ = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT    = 2'd1;

  // Surface codes of the result.
  localparam logic [1:0] SURF_SIDE   = 2'd0;
  localparam logic [1:0] SURF_BOTTOM = 2'd1;
  localparam logic [1:0] SURF_TOP    = 2'd2;

  // Position of a root against the slab between the caps.
  localparam logic [1:0] SLAB_IN    = 2'd0;
  localparam logic [1:0] SLAB_ABOVE = 2'd1;
  localparam logic [1:0] SLAB_BELOW = 2'd2;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_enter;
    logic [1:0]         enter_surface;
    logic signed [31:0] t_exit;
    logic [1:0]         exit_surface;
  } result_t;

  // Values that ride along with the discriminant through the square root.
  typedef struct packed {
    logic               miss;
    logic [63:0]        a;
    logic signed [64:0] b;
    logic signed [31:0] oy;
    logic signed [31:0] dy;
  } side_t;

  typedef struct packed {
    logic [127:0] rad;
    side_t        side;
  } sqrt_in_t;

  typedef struct packed {
    logic [63:0] root;
    side_t       side;
  } sqrt_out_t;

  // Values that ride along with the four quotients through the divider.
  typedef struct packed {
    logic               miss;
    logic [DivLanes-1:0] neg;
    logic               dy_zero;
    logic signed [31:0] oy;
    logic signed [31:0] dy;
  } dside_t;

  typedef struct packed {
    logic [DivLanes-1:0][80:0] num;
    logic [DivLanes-1:0][63:0] den;
    dside_t                    side;
  } div_in_t;

  typedef struct packed {
    logic [DivLanes-1:0][31:0] quo;
    logic [DivLanes-1:0]       ovf;
    logic [DivLanes-1:0]       inexact;
    dside_t                    side;
  } div_out_t;

endpackage

// ===== sv/rcci_front.sv =====
// Front end: products, quadratic coefficients and discriminant in six stages.
// Depends on rcci_pkg; feeds rcci_sqrt.
module rcci_front
  import rcci_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  ray_t        in_data,
  input  logic [30:0] radius_sq,
  output logic        out_valid,
  output sqrt_in_t    out_data
);

  // Stage 1: the six 32x32 products.
  logic               s1_vld_r;
  ray_t               s1_ray_r;
  logic signed [63:0] s1_dxx_r, s1_dzz_r, s1_oxx_r, s1_ozz_r, s1_oxdx_r, s1_ozdz_r;

  // Stage 2: a, b and c.
  logic        s2_vld_r;
  side_t       s2_side_r;
  logic        s2_cneg_r;
  logic [63:0] s2_cmag_r, s2_bmag_r;
  logic [63:0] s2_a_nxt, s2_sq_nxt, s2_r2s_nxt, s2_bmag_nxt;
  logic signed [64:0] s2_b_nxt;

  // Stage 3: 32x32 partial products of b*b and a*c.
  logic        s3_vld_r;
  side_t       s3_side_r;
  logic        s3_cneg_r;
  logic [3:0][63:0] s3_bb_r, s3_ac_r;

  // Stage 4: middle terms summed.
  logic        s4_vld_r;
  side_t       s4_side_r;
  logic        s4_cneg_r;
  logic [63:0] s4_bb_lo_r, s4_bb_hi_r, s4_ac_lo_r, s4_ac_hi_r;
  logic [64:0] s4_bb_mid_r, s4_ac_mid_r;

  // Stage 5: full 128-bit products.
  logic         s5_vld_r;
  side_t        s5_side_r;
  logic         s5_cneg_r;
  logic [127:0] s5_bb_r, s5_ac_r;

  // Stage 6: discriminant.
  logic         s6_vld_r;
  sqrt_in_t     s6_data_r;
  logic [128:0] s6_disc_nxt;
  logic         s6_miss_nxt;
  side_t        s6_side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ray_r  <= in_data;
      s1_dxx_r  <= in_data.dir_x * in_data.dir_x;
      s1_dzz_r  <= in_data.dir_z * in_data.dir_z;
      s1_oxx_r  <= in_data.origin_x * in_data.origin_x;
      s1_ozz_r  <= in_data.origin_z * in_data.origin_z;
      s1_oxdx_r <= in_data.origin_x * in_data.dir_x;
      s1_ozdz_r <= in_data.origin_z * in_data.dir_z;
    end
  end

  always_comb begin
    s2_a_nxt    = $unsigned(s1_dxx_r) + $unsigned(s1_dzz_r);
    s2_sq_nxt   = $unsigned(s1_oxx_r) + $unsigned(s1_ozz_r);
    s2_r2s_nxt  = {17'b0, radius_sq, 16'b0};
    s2_b_nxt    = -(65'(s1_oxdx_r) + 65'(s1_ozdz_r));
    s2_bmag_nxt = s2_b_nxt[64] ? 64'(-s2_b_nxt) : s2_b_nxt[63:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side_r.miss <= (s2_a_nxt == 64'd0);
      s2_side_r.a    <= s2_a_nxt;
      s2_side_r.b    <= s2_b_nxt;
      s2_side_r.oy   <= s1_ray_r.origin_y;
      s2_side_r.dy   <= s1_ray_r.dir_y;
      s2_cneg_r      <= (s2_sq_nxt < s2_r2s_nxt);
      s2_cmag_r      <= (s2_sq_nxt < s2_r2s_nxt) ? s2_r2s_nxt - s2_sq_nxt
                                                 : s2_sq_nxt - s2_r2s_nxt;
      s2_bmag_r      <= s2_bmag_nxt;
    end
  end

  // Partial product order: [0] lo*lo, [1] lo*hi, [2] hi*lo, [3] hi*hi.
  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r  <= s2_side_r;
      s3_cneg_r  <= s2_cneg_r;
      s3_bb_r[0] <= s2_bmag_r[31:0] * s2_bmag_r[31:0];
      s3_bb_r[1] <= s2_bmag_r[31:0] * s2_bmag_r[63:32];
      s3_bb_r[2] <= s2_bmag_r[63:32] * s2_bmag_r[31:0];
      s3_bb_r[3] <= s2_bmag_r[63:32] * s2_bmag_r[63:32];
      s3_ac_r[0] <= s2_side_r.a[31:0] * s2_cmag_r[31:0];
      s3_ac_r[1] <= s2_side_r.a[31:0] * s2_cmag_r[63:32];
      s3_ac_r[2] <= s2_side_r.a[63:32] * s2_cmag_r[31:0];
      s3_ac_r[3] <= s2_side_r.a[63:32] * s2_cmag_r[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r   <= s3_side_r;
      s4_cneg_r   <= s3_cneg_r;
      s4_bb_lo_r  <= s3_bb_r[0];
      s4_bb_hi_r  <= s3_bb_r[3];
      s4_bb_mid_r <= {1'b0, s3_bb_r[1]} + {1'b0, s3_bb_r[2]};
      s4_ac_lo_r  <= s3_ac_r[0];
      s4_ac_hi_r  <= s3_ac_r[3];
      s4_ac_mid_r <= {1'b0, s3_ac_r[1]} + {1'b0, s3_ac_r[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side_r <= s4_side_r;
      s5_cneg_r <= s4_cneg_r;
      s5_bb_r   <= {s4_bb_hi_r, 64'b0} + {31'b0, s4_bb_mid_r, 32'b0} + {64'b0, s4_bb_lo_r};
      s5_ac_r   <= {s4_ac_hi_r, 64'b0} + {31'b0, s4_ac_mid_r, 32'b0} + {64'b0, s4_ac_lo_r};
    end
  end

  // With c negative the discriminant is a sum and cannot go below zero.
  always_comb begin
    s6_disc_nxt = s5_cneg_r ? {1'b0, s5_bb_r} + {1'b0, s5_ac_r}
                            : {1'b0, s5_bb_r} - {1'b0, s5_ac_r};
    s6_miss_nxt = s5_side_r.miss || (!s5_cneg_r && s6_disc_nxt[128]);
    s6_side_nxt      = s5_side_r;
    s6_side_nxt.miss = s6_miss_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_data_r.side <= s6_side_nxt;
      s6_data_r.rad  <= s6_miss_nxt ? 128'd0 : s6_disc_nxt[127:0];
    end
  end

  assign out_valid = s6_vld_r;
  assign out_data  = s6_data_r;

endmodule

// ===== sv/rcci_sqrt.sv =====
// Pipelined integer square root of a 128-bit discriminant, one result bit per stage.
// Depends on rcci_pkg; fed by rcci_front.
module rcci_sqrt
  import rcci_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  sqrt_in_t  in_data,
  output logic      out_valid,
  output sqrt_out_t out_data
);

  logic         vld_r  [SqrtSteps];
  logic [64:0]  rem_r  [SqrtSteps];
  logic [63:0]  root_r [SqrtSteps];
  logic [127:0] rad_r  [SqrtSteps];
  side_t        side_r [SqrtSteps];

  logic         src_vld  [SqrtSteps];
  logic [64:0]  src_rem  [SqrtSteps];
  logic [63:0]  src_root [SqrtSteps];
  logic [127:0] src_rad  [SqrtSteps];
  side_t        src_side [SqrtSteps];

  logic [66:0]  rem_sh   [SqrtSteps];
  logic [66:0]  trial    [SqrtSteps];
  logic [64:0]  rem_nxt  [SqrtSteps];
  logic [63:0]  root_nxt [SqrtSteps];

  always_comb begin
    src_vld[0]  = in_valid;
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_rad[0]  = in_data.rad;
    src_side[0] = in_data.side;
    for (int k = 1; k < SqrtSteps; k++) begin
      src_vld[k]  = vld_r[k-1];
      src_rem[k]  = rem_r[k-1];
      src_root[k] = root_r[k-1];
      src_rad[k]  = rad_r[k-1];
      src_side[k] = side_r[k-1];
    end
  end

  // Classic digit-by-digit root: bring down two radicand bits, try 4*root+1.
  always_comb begin
    for (int k = 0; k < SqrtSteps; k++) begin
      rem_sh[k] = {src_rem[k], src_rad[k][127:126]};
      trial[k]  = {1'b0, src_root[k], 2'b01};
      if (rem_sh[k] >= trial[k]) begin
        rem_nxt[k]  = 65'(rem_sh[k] - trial[k]);
        root_nxt[k] = {src_root[k][62:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_sh[k][64:0];
        root_nxt[k] = {src_root[k][62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SqrtSteps; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < SqrtSteps; k++) vld_r[k] <= src_vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SqrtSteps; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= {src_rad[k][125:0], 2'b00};
        side_r[k] <= src_side[k];
      end
    end
  end

  assign out_valid     = vld_r[SqrtSteps-1];
  assign out_data.root = root_r[SqrtSteps-1];
  assign out_data.side = side_r[SqrtSteps-1];

endmodule

// ===== sv/rcci_div.sv =====
// Four-lane pipelined restoring divider: overflow check, then one quotient bit per stage.
// Depends on rcci_pkg; gives 32-bit quotients with overflow and remainder flags.
module rcci_div
  import rcci_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  div_in_t  in_data,
  output logic     out_valid,
  output div_out_t out_data
);

  localparam int unsigned Stages = DivSteps + 1;

  logic        vld_r  [Stages];
  dside_t      side_r [Stages];
  logic [63:0] rem_r  [Stages][DivLanes];
  logic [63:0] den_r  [Stages][DivLanes];
  logic [31:0] low_r  [Stages][DivLanes];
  logic [31:0] quo_r  [Stages][DivLanes];
  logic        ovf_r  [Stages][DivLanes];

  logic        ovf0_nxt [DivLanes];
  logic [64:0] rem_sh   [DivSteps][DivLanes];
  logic        take     [DivSteps][DivLanes];

  // Stage 0: a quotient of 2^32 or more saturates in any case.
  always_comb begin
    for (int l = 0; l < DivLanes; l++) begin
      ovf0_nxt[l] = ({15'b0, in_data.num[l]} >= {in_data.den[l], 32'b0});
    end
  end

  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      for (int l = 0; l < DivLanes; l++) begin
        rem_sh[k][l] = {rem_r[k][l], low_r[k][l][31]};
        take[k][l]   = (rem_sh[k][l] >= {1'b0, den_r[k][l]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < Stages; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < Stages; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_data.side;
      for (int l = 0; l < DivLanes; l++) begin
        ovf_r[0][l] <= ovf0_nxt[l];
        rem_r[0][l] <= ovf0_nxt[l] ? 64'd0 : {15'b0, in_data.num[l][80:32]};
        low_r[0][l] <= in_data.num[l][31:0];
        den_r[0][l] <= in_data.den[l];
        quo_r[0][l] <= 32'd0;
      end
      for (int k = 1; k < Stages; k++) begin
        side_r[k] <= side_r[k-1];
        for (int l = 0; l < DivLanes; l++) begin
          ovf_r[k][l] <= ovf_r[k-1][l];
          den_r[k][l] <= den_r[k-1][l];
          low_r[k][l] <= {low_r[k-1][l][30:0], 1'b0};
          quo_r[k][l] <= {quo_r[k-1][l][30:0], take[k-1][l]};
          rem_r[k][l] <= take[k-1][l] ? 64'(rem_sh[k-1][l] - {1'b0, den_r[k-1][l]})
                                      : rem_sh[k-1][l][63:0];
        end
      end
    end
  end

  always_comb begin
    out_data.side = side_r[Stages-1];
    for (int l = 0; l < DivLanes; l++) begin
      out_data.quo[l]     = quo_r[Stages-1][l];
      out_data.ovf[l]     = ovf_r[Stages-1][l];
      out_data.inexact[l] = (rem_r[Stages-1][l] != 64'd0);
    end
  end

  assign out_valid = vld_r[Stages-1];

endmodule

// ===== sv/ray_capped_cylinder_intersect.sv =====
// Ray against a capped cylinder along the local y axis, signed Q16.16, fully pipelined.
// Depends on rcci_pkg, rcci_front, rcci_sqrt and rcci_div.
//
// Use: rays enter on in_valid/in_ready (in_data), results leave on out_valid/out_ready
// (out_data), one result per ray, in ray order. While out_ready is high, a transfer can happen on
// both sides in every cycle, so the sustained rate is one ray per clock.
// An input transfer reaches out_valid through six stages for the products and
// discriminant, 64 square root stages (one root bit each), one stage to form the four
// numerators, 33 divider stages (overflow check plus one quotient bit each), two stages
// for saturation and the slab products, and the output register.
// All stages advance together; while out_valid is high and out_ready low the whole
// pipeline holds and in_ready is low, so nothing is lost or repeated. The output
// register itself is free again in the cycle its result is taken.
// radius_squared and cyl_height are written on cfg_we/cfg_index/cfg_wdata and must
// only change while no ray is in flight. Reset empties the pipeline and sets both
// registers to 1.0.
module ray_capped_cylinder_intersect
  import rcci_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ray_t               in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [30:0]        cfg_wdata
);

  localparam int unsigned LaneT1  = 0;
  localparam int unsigned LaneT2  = 1;
  localparam int unsigned LaneBot = 2;
  localparam int unsigned LaneTop = 3;

  logic [30:0] radius_sq_r, height_r;
  logic        en;

  logic      fr_vld;
  sqrt_in_t  fr_data;
  logic      sq_vld;
  sqrt_out_t sq_data;

  // Numerator preparation stage.
  logic               p_vld_r;
  div_in_t            p_data_r;
  logic signed [65:0] p_m1, p_m2;
  logic signed [33:0] p_bot_diff, p_top_diff;
  logic [31:0]        p_abs_dy;
  logic               p_dy_zero;

  logic     dv_vld;
  div_out_t dv_data;

  // Saturated distances.
  logic               b1_vld_r, b1_miss_r;
  logic signed [31:0] b1_t1_r, b1_t2_r, b1_tb_r, b1_tt_r, b1_oy_r, b1_dy_r;

  // Axis position products.
  logic               b2_vld_r, b2_miss_r;
  logic signed [31:0] b2_t1_r, b2_t2_r, b2_tb_r, b2_tt_r, b2_oy_r;
  logic signed [63:0] b2_y1p_r, b2_y2p_r;

  logic signed [63:0] y1, y2, y_top;
  logic [1:0]         c1, c2;
  result_t            res_nxt;

  logic    out_valid_r;
  result_t out_data_r;

  function automatic logic signed [31:0] sat_floor(input logic neg, input logic [31:0] q,
                                                   input logic ovf, input logic inexact);
    logic [31:0] mag;
    logic [31:0] res;
    mag = q + {31'b0, inexact};
    if (ovf || q[31]) begin
      res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg) begin
      res = 32'd0 - mag;
    end else begin
      res = q;
    end
    return $signed(res);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_sq_r <= 31'd65536;
      height_r    <= 31'd65536;
    end else if (cfg_we) begin
      if (cfg_index == REG_RADIUS_SQ) radius_sq_r <= cfg_wdata;
      if (cfg_index == REG_HEIGHT)    height_r    <= cfg_wdata;
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  rcci_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .radius_sq (radius_sq_r),
    .out_valid (fr_vld),
    .out_data  (fr_data)
  );

  rcci_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_vld),
    .in_data   (fr_data),
    .out_valid (sq_vld),
    .out_data  (sq_data)
  );

  // Roots are (b -/+ s)/a; cap crossings are (level - oy)/dy, all scaled by 2^16.
  always_comb begin
    p_m1       = 66'(sq_data.side.b) - $signed({2'b00, sq_data.root});
    p_m2       = 66'(sq_data.side.b) + $signed({2'b00, sq_data.root});
    p_bot_diff = 34'sd0 - 34'(sq_data.side.oy);
    p_top_diff = $signed({3'b000, height_r}) - 34'(sq_data.side.oy);
    p_abs_dy   = sq_data.side.dy[31] ? 32'(-33'(sq_data.side.dy))
                                     : $unsigned(sq_data.side.dy);
    p_dy_zero  = (sq_data.side.dy == 32'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_data_r.num[LaneT1]  <= {(p_m1[65] ? 65'(-p_m1) : p_m1[64:0]), 16'b0};
      p_data_r.num[LaneT2]  <= {(p_m2[65] ? 65'(-p_m2) : p_m2[64:0]), 16'b0};
      p_data_r.num[LaneBot] <= {32'b0, (p_bot_diff[33] ? 33'(-p_bot_diff)
                                                       : p_bot_diff[32:0]), 16'b0};
      p_data_r.num[LaneTop] <= {32'b0, (p_top_diff[33] ? 33'(-p_top_diff)
                                                       : p_top_diff[32:0]), 16'b0};
      p_data_r.den[LaneT1]  <= sq_data.side.a;
      p_data_r.den[LaneT2]  <= sq_data.side.a;
      p_data_r.den[LaneBot] <= p_dy_zero ? 64'd1 : {32'b0, p_abs_dy};
      p_data_r.den[LaneTop] <= p_dy_zero ? 64'd1 : {32'b0, p_abs_dy};
      p_data_r.side.neg[LaneT1]  <= p_m1[65];
      p_data_r.side.neg[LaneT2]  <= p_m2[65];
      p_data_r.side.neg[LaneBot] <= p_bot_diff[33] != sq_data.side.dy[31];
      p_data_r.side.neg[LaneTop] <= p_top_diff[33] != sq_data.side.dy[31];
      p_data_r.side.miss    <= sq_data.side.miss;
      p_data_r.side.dy_zero <= p_dy_zero;
      p_data_r.side.oy      <= sq_data.side.oy;
      p_data_r.side.dy      <= sq_data.side.dy;
    end
  end

  rcci_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_vld_r),
    .in_data   (p_data_r),
    .out_valid (dv_vld),
    .out_data  (dv_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r    <= 1'b0;
      b2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b1_vld_r    <= dv_vld;
      b2_vld_r    <= b1_vld_r;
      out_valid_r <= b2_vld_r;
    end
  end

  // A cap crossing with dy = 0 is never selected; it reads as zero.
  always_ff @(posedge clk) begin
    if (en) begin
      b1_miss_r <= dv_data.side.miss;
      b1_oy_r   <= dv_data.side.oy;
      b1_dy_r   <= dv_data.side.dy;
      b1_t1_r   <= sat_floor(dv_data.side.neg[LaneT1], dv_data.quo[LaneT1],
                             dv_data.ovf[LaneT1], dv_data.inexact[LaneT1]);
      b1_t2_r   <= sat_floor(dv_data.side.neg[LaneT2], dv_data.quo[LaneT2],
                             dv_data.ovf[LaneT2], dv_data.inexact[LaneT2]);
      b1_tb_r   <= dv_data.side.dy_zero ? 32'sd0
                 : sat_floor(dv_data.side.neg[LaneBot], dv_data.quo[LaneBot],
                             dv_data.ovf[LaneBot], dv_data.inexact[LaneBot]);
      b1_tt_r   <= dv_data.side.dy_zero ? 32'sd0
                 : sat_floor(dv_data.side.neg[LaneTop], dv_data.quo[LaneTop],
                             dv_data.ovf[LaneTop], dv_data.inexact[LaneTop]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_miss_r <= b1_miss_r;
      b2_oy_r   <= b1_oy_r;
      b2_t1_r   <= b1_t1_r;
      b2_t2_r   <= b1_t2_r;
      b2_tb_r   <= b1_tb_r;
      b2_tt_r   <= b1_tt_r;
      b2_y1p_r  <= b1_dy_r * b1_t1_r;
      b2_y2p_r  <= b1_dy_r * b1_t2_r;
    end
  end

  // Axis position of each root, scaled by 2^32, against the two cap planes.
  always_comb begin
    y1    = b2_y1p_r + (64'(b2_oy_r) <<< 16);
    y2    = b2_y2p_r + (64'(b2_oy_r) <<< 16);
    y_top = $signed({17'b0, height_r, 16'b0});
    c1    = (y1 < 0) ? SLAB_BELOW : ((y1 > y_top) ? SLAB_ABOVE : SLAB_IN);
    c2    = (y2 < 0) ? SLAB_BELOW : ((y2 > y_top) ? SLAB_ABOVE : SLAB_IN);
    res_nxt = '0;
    if (!b2_miss_r && !(c1 != SLAB_IN && c1 == c2)) begin
      res_nxt.hit = 1'b1;
      unique case (c1)
        SLAB_IN: begin
          res_nxt.t_enter       = b2_t1_r;
          res_nxt.enter_surface = SURF_SIDE;
        end
        SLAB_ABOVE: begin
          res_nxt.t_enter       = b2_tt_r;
          res_nxt.enter_surface = SURF_TOP;
        end
        default: begin
          res_nxt.t_enter       = b2_tb_r;
          res_nxt.enter_surface = SURF_BOTTOM;
        end
      endcase
      unique case (c2)
        SLAB_IN: begin
          res_nxt.t_exit       = b2_t2_r;
          res_nxt.exit_surface = SURF_SIDE;
        end
        SLAB_ABOVE: begin
          res_nxt.t_exit       = b2_tt_r;
          res_nxt.exit_surface = SURF_TOP;
        end
        default: begin
          res_nxt.t_exit       = b2_tb_r;
          res_nxt.exit_surface = SURF_BOTTOM;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.t_enter == 32'sd0 && out_data.t_exit == 32'sd0
      && out_data.enter_surface == SURF_SIDE && out_data.exit_surface == SURF_SIDE)
    else $error("miss result carries nonzero fields");

  a_side_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit && out_data.enter_surface == SURF_SIDE
      && out_data.exit_surface == SURF_SIDE |-> out_data.t_enter <= out_data.t_exit)
    else $error("side entry lies after side exit");

  a_caps_differ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.enter_surface == SURF_SIDE
      || out_data.enter_surface != out_data.exit_surface)
    else $error("hit enters and exits through the same cap");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> out_valid)
    else $error("pipeline stalled without a held result");

endmodule

// ===== tb/ray_capped_cylinder_intersect_tb.sv =====
// Self-checking testbench for ray_capped_cylinder_intersect: streams rays, predicts each
// result with an exact wide-integer model of the intersection and compares in order.
// Depends on rcci_pkg and the block's RTL.
module ray_capped_cylinder_intersect_tb;
  import rcci_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 65536;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  ray_t               in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  result_t            out_data;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [30:0]        cfg_wdata = '0;

  logic [30:0] radius_sq_q = 31'(ONE);
  logic [30:0] height_q = 31'(ONE);
  result_t     expected_hits[$];
  int          error_count = 0;
  bit          quiet = 1'b0;
  int          stall_left = 0;

  ray_capped_cylinder_intersect dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0]  r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = {64'b0, r | (64'b1 << b)};
      if (c * c <= v) r = c[63:0];
    end
    return r;
  endfunction

  // Quotient rounded toward minus infinity, saturated to 32 bits.
  function automatic logic signed [31:0] floor_div_sat(logic signed [159:0] num,
                                                        logic signed [159:0] den);
    logic signed [159:0] q, r;
    q = num / den;
    r = num % den;
    if (r != 0 && ((r < 0) != (den < 0))) q = q - 1;
    if (q > 160'sd2147483647) return 32'sh7FFFFFFF;
    if (q < -160'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic logic [1:0] slab_of(logic signed [31:0] t, logic signed [159:0] oy,
                                         logic signed [159:0] dy);
    logic signed [159:0] y, tt, top;
    tt = t;
    top = height_q;
    y = dy * tt + oy * ONE;
    if (y < 0) return SLAB_BELOW;
    if (y > top * ONE) return SLAB_ABOVE;
    return SLAB_IN;
  endfunction

  function automatic logic signed [31:0] cap_crossing(logic signed [159:0] level,
                                                       logic signed [159:0] oy,
                                                       logic signed [159:0] dy);
    if (dy == 0) return '0;
    return floor_div_sat((level - oy) * ONE, dy);
  endfunction

  function automatic result_t predict_intersection(ray_t r);
    logic signed [159:0] ox, oy, oz, dx, dy, dz, a, b, c, disc, s, r2, lvl;
    logic signed [31:0]  t1, t2;
    logic [1:0]          c1, c2;
    result_t             res;
    res = '0;
    ox = r.origin_x; oy = r.origin_y; oz = r.origin_z;
    dx = r.dir_x; dy = r.dir_y; dz = r.dir_z;
    r2 = radius_sq_q;
    lvl = height_q;
    a = dx * dx + dz * dz;
    if (a == 0) return res;
    c = ox * ox + oz * oz - r2 * ONE;
    b = -(ox * dx + oz * dz);
    disc = b * b - a * c;
    if (disc < 0) return res;
    s = {96'b0, isqrt(disc[127:0])};
    t1 = floor_div_sat((b - s) * ONE, a);
    t2 = floor_div_sat((b + s) * ONE, a);
    c1 = slab_of(t1, oy, dy);
    c2 = slab_of(t2, oy, dy);
    if (c1 != SLAB_IN && c1 == c2) return res;
    res.hit = 1'b1;
    case (c1)
      SLAB_IN:    begin res.t_enter = t1; res.enter_surface = SURF_SIDE; end
      SLAB_ABOVE: begin res.t_enter = cap_crossing(lvl, oy, dy); res.enter_surface = SURF_TOP; end
      default:    begin res.t_enter = cap_crossing(0, oy, dy); res.enter_surface = SURF_BOTTOM; end
    endcase
    case (c2)
      SLAB_IN:    begin res.t_exit = t2; res.exit_surface = SURF_SIDE; end
      SLAB_ABOVE: begin res.t_exit = cap_crossing(lvl, oy, dy); res.exit_surface = SURF_TOP; end
      default:    begin res.t_exit = cap_crossing(0, oy, dy); res.exit_surface = SURF_BOTTOM; end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Result side: random back-pressure bursts and in-order checking.
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data.t_enter), 64'd0);
        end else begin
          want = expected_hits.pop_front();
          if (out_data.hit !== want.hit)
            report_mismatch("hit", 64'(out_data.hit), 64'(want.hit));
          if (out_data.t_enter !== want.t_enter)
            report_mismatch("t_enter", 64'(out_data.t_enter), 64'(want.t_enter));
          if (out_data.enter_surface !== want.enter_surface)
            report_mismatch("enter_surface", 64'(out_data.enter_surface),
                            64'(want.enter_surface));
          if (out_data.t_exit !== want.t_exit)
            report_mismatch("t_exit", 64'(out_data.t_exit), 64'(want.t_exit));
          if (out_data.exit_surface !== want.exit_surface)
            report_mismatch("exit_surface", 64'(out_data.exit_surface),
                            64'(want.exit_surface));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_ray(ray_t r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    expected_hits.push_back(predict_intersection(r));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  // The write enable drops for one cycle after each write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RADIUS_SQ) radius_sq_q = val;
    else if (idx == REG_HEIGHT) height_q = val;
    @(posedge clk);
  endtask

  function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    return r;
  endfunction

  function automatic int spread(int k);
    return int'($urandom_range(0, 2 * k)) - k;
  endfunction

  // Mostly rays aimed near the cylinder at the given scale, the rest raw noise.
  function automatic ray_t random_ray(int span);
    ray_t r;
    if ($urandom_range(0, 4) == 0) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      r = mk(spread(3 * span), spread(2 * span), spread(3 * span),
             spread(span), spread(span), spread(span));
      if ($urandom_range(0, 9) == 0) r.dir_y = 0;
      if ($urandom_range(0, 19) == 0) begin r.dir_x = 0; r.dir_z = 0; end
    end
    return r;
  endfunction

  task automatic test_directed;
    int half;
    half = ONE / 2;
    send_ray(mk(0, half, 0, 0, ONE, 0));              // parallel to the axis
    send_ray(mk(0, 0, 0, 0, 0, 0));                   // zero direction
    send_ray(mk(-3 * ONE, half, 5 * ONE, ONE, 0, 0)); // passes beside the side
    send_ray(mk(-3 * ONE, half, 0, ONE, 0, 0));       // side in, side out
    send_ray(mk(0, -2 * ONE, 0, ONE / 100, ONE, 0));  // bottom cap in, top cap out
    send_ray(mk(0, 3 * ONE, 0, ONE / 100, -ONE, 0));  // top cap in, bottom cap out
    send_ray(mk(-3 * ONE, 5 * ONE, 0, ONE, 0, 0));    // both roots above
    send_ray(mk(-3 * ONE, -5 * ONE, 0, ONE, 0, 0));   // both roots below
    send_ray(mk(0, half, 0, ONE, 0, 0));              // origin inside
    send_ray(mk(3 * ONE, half, 0, ONE, 0, 0));        // pointing away
    send_ray(mk(-2 * ONE, half, 0, ONE, half, 0));    // side in, top out
    send_ray(mk(-2 * ONE, half, 0, ONE, -half, 0));   // side in, bottom out
    send_ray(mk(ONE, half, 0, 0, 0, ONE));            // tangent
    send_ray(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF));
    send_ray(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000));
    send_ray(mk(0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000));
    send_ray(mk(32'h80000000, 0, 0, 1, 0, 0));        // huge distance saturates
    send_ray(mk(0, half, 0, 1, 1, 1));                // tiny direction
    send_ray(mk(-1, -1, -1, -1, -1, -1));
    drain();
  endtask

  task automatic test_random_rays(int count, int span);
    repeat (count) send_ray(random_ray(span));
  endtask

  task automatic test_config_phase(logic [30:0] rsq, logic [30:0] hgt, int count, int span);
    drain();
    write_reg(REG_RADIUS_SQ, rsq);
    write_reg(REG_HEIGHT, hgt);
    test_random_rays(count, span);
  endtask

  task automatic test_ignored_index;
    drain();
    write_reg(2'd2, 31'h1234);
    write_reg(2'd3, 31'h7FFFFFFF);
    test_directed();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_rays(300, ONE);
    test_config_phase(31'h0, 31'h0, 250, ONE);
    test_config_phase(31'h7FFFFFFF, 31'h7FFFFFFF, 300, 181 * ONE);
    test_config_phase(31'(4 * ONE), 31'(3 * ONE), 300, 2 * ONE);
    test_ignored_index();
    test_config_phase(31'(ONE / 4), 31'(5 * ONE), 300, ONE / 2);
    test_config_phase(31'(ONE), 31'(ONE), 100, ONE);
    quiet = 1'b1;
    test_random_rays(300, ONE);
    drain();
    repeat (120) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rcci_pkg.sv
sv/rcci_front.sv
sv/rcci_sqrt.sv
sv/rcci_div.sv
sv/ray_capped_cylinder_intersect.sv
tb/ray_capped_cylinder_intersect_tb.sv
